// ===== hdl/bfns_pkg.sv =====
package bfns_pkg;

  // Table and search sizing
  localparam int TABLE_DEPTH = 65536;
  localparam int FLIP_BITS   = 32;
  localparam int MAX_OUT     = 32;
  localparam int NUM_BITS    = (FLIP_BITS < MAX_OUT) ? FLIP_BITS : MAX_OUT;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int FRAME_W = 52;
  localparam int SLOT_W  = 16;
  localparam int OFF_W   = 12;
  localparam int BIT_W   = $clog2(MAX_OUT);
  localparam int ADDR64_W = 64;

  // Input beat action codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  slot;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;      // empty the table
    logic append;     // add one entry
    logic start;      // latch query, set up search of bit 0
    logic step;       // one binary search step
    logic next_bit;   // set up search of the next bit
    logic push;       // pending hit to output, not last
    logic keep;       // current hit becomes pending
    logic fin;        // final result to output
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic search_done;
    logic found;
    logic pend_valid;
    logic out_free;
    logic last_bit;
  } dp_sts_t;

endpackage

// ===== hdl/bfns_ram.sv =====
module bfns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bfns_ctrl.sv =====
module bfns_ctrl import bfns_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  output logic          in_ready_o,
  input  dp_sts_t       sts_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_RESULT = 4'b0100,
    S_FINAL  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   need_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  // a new hit displaces a pending one, which needs the output register
  assign need_out   = sts_i.found & sts_i.pend_valid;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ACT_CLEAR:  cmd_o.clear  = 1'b1;
            ACT_APPEND: cmd_o.append = 1'b1;
            ACT_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = S_SEARCH;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.search_done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!need_out || sts_i.out_free) begin
          cmd_o.push = need_out;
          cmd_o.keep = sts_i.found;
          if (sts_i.last_bit) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.next_bit = 1'b1;
            state_d        = S_SEARCH;
          end
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/bfns_dp.sv =====
module bfns_dp import bfns_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ADDR64_W-1:0] cfg_wdata_i,
  input  logic [FRAME_W-1:0]  entry_frame_i,
  input  logic [SLOT_W-1:0]   entry_slot_i,
  input  logic [FRAME_W-1:0]  base_frame_i,
  input  logic [OFF_W-1:0]    page_offset_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                hit_o,
  output logic [BIT_W-1:0]    flip_bit_o,
  output logic [ADDR64_W-1:0] target_phys_o,
  output logic [ADDR64_W-1:0] target_virt_o,
  output logic [ADDR64_W-1:0] origin_phys_o,
  output logic                last_o
);

  // control state
  logic [CNT_W-1:0]    cnt_q;
  logic [ADDR64_W-1:0] pool_base_q;
  logic                rd_pend_q;
  logic                found_q;
  logic                pend_valid_q;
  logic                out_valid_q;

  // query and search payload
  logic [FRAME_W-1:0]  base_q;
  logic [OFF_W-1:0]    off_q;
  logic [BIT_W-1:0]    bit_q;
  logic [CNT_W-1:0]    lo_q, hi_q;
  logic [ADDR_W-1:0]   mid_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [BIT_W-1:0]    pend_bit_q;
  logic [SLOT_W-1:0]   pend_slot_q;

  // output register
  logic                hit_q, last_q;
  logic [BIT_W-1:0]    flip_bit_q;
  logic [ADDR64_W-1:0] tphys_q, tvirt_q, bphys_q;

  logic                full;
  logic [FRAME_W-1:0]  key, pend_key;
  entry_t              rd_entry, wr_entry;
  logic [$bits(entry_t)-1:0] rdata;
  logic                lt;
  logic [CNT_W-1:0]    lo_n, hi_n;
  logic [CNT_W:0]      mid_sum;
  logic [ADDR_W-1:0]   mid_n;
  logic                done;

  assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign key      = base_q ^ (FRAME_W'(1) << bit_q);
  assign pend_key = base_q ^ (FRAME_W'(1) << pend_bit_q);
  assign rd_entry = entry_t'(rdata);
  assign wr_entry = '{frame: entry_frame_i, slot: entry_slot_i};
  assign lt       = (rd_entry.frame < key);

  // lower-bound step: fold in last read, then pick next probe
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rd_pend_q) begin
      if (lt) begin
        lo_n = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        hi_n = CNT_W'(mid_q);
      end
    end
  end

  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = mid_sum[ADDR_W:1];
  assign done    = (lo_n >= hi_n);

  bfns_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append & ~full),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.step & ~done),
    .raddr_i (mid_n),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pool_base_q  <= '0;
      rd_pend_q    <= 1'b0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.append && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.start || cmd_i.next_bit) begin
        rd_pend_q <= 1'b0;
        found_q   <= 1'b0;
      end else if (cmd_i.step) begin
        rd_pend_q <= ~done;
        if (rd_pend_q && !lt) begin
          found_q <= (rd_entry.frame == key);
        end
      end
      if (cmd_i.start) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.keep) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.push || cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      base_q <= base_frame_i;
      off_q  <= page_offset_i;
      bit_q  <= '0;
    end else if (cmd_i.next_bit) begin
      bit_q <= bit_q + BIT_W'(1);
    end
    if (cmd_i.start || cmd_i.next_bit) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end else if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
      // the entry that last lowered hi is the lower-bound position
      if (rd_pend_q && !lt) begin
        slot_q <= rd_entry.slot;
      end
    end
    if (cmd_i.keep) begin
      pend_bit_q  <= bit_q;
      pend_slot_q <= slot_q;
    end
    if (cmd_i.push || (cmd_i.fin && pend_valid_q)) begin
      hit_q      <= 1'b1;
      flip_bit_q <= pend_bit_q;
      tphys_q    <= {pend_key, off_q};
      tvirt_q    <= pool_base_q + ADDR64_W'({pend_slot_q, off_q});
      bphys_q    <= {base_q, off_q};
      last_q     <= cmd_i.fin;
    end else if (cmd_i.fin) begin
      hit_q      <= 1'b0;
      flip_bit_q <= '0;
      tphys_q    <= '0;
      tvirt_q    <= '0;
      bphys_q    <= {base_q, off_q};
      last_q     <= 1'b1;
    end
  end

  assign sts_o.search_done = done;
  assign sts_o.found       = found_q;
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;
  assign sts_o.last_bit    = (bit_q == BIT_W'(NUM_BITS - 1));

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign flip_bit_o    = flip_bit_q;
  assign target_phys_o = tphys_q;
  assign target_virt_o = tvirt_q;
  assign origin_phys_o = bphys_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/bit_flip_neighbour_search_core.sv =====
// Bit-flip neighbour search core.
// Input channel (in_valid_i/in_ready_o) carries one action per beat: clear the
// table, append a (frame, slot) entry, or query a base frame with a page offset.
// Entries must be appended in ascending frame order. Clear and append produce
// no output beat, so they can stream one per cycle. A query flips each of the
// low 32 frame bits in turn and runs a lower-bound binary search of the table,
// one table read per cycle through the single RAM read port, then emits the
// final beat. The input is not ready while a query runs. Each hit gives one
// output beat in ascending bit order with last_o on the final one; a query with
// no hit gives a single beat with hit_o low. A hit is held back one step so
// last_o can be set, and the output register lets the next input be taken
// while a beat waits. While a beat waits with out_ready_i low, the search
// pauses at the next hit until the beat is taken. cfg_we_i writes the pool
// base; write only while idle. Reset empties the table and clears the pool
// base; there is no clearing pass.
module bit_flip_neighbour_search_core import bfns_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ADDR64_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [FRAME_W-1:0]  entry_frame_i,
  input  logic [SLOT_W-1:0]   entry_slot_i,
  input  logic [FRAME_W-1:0]  base_frame_i,
  input  logic [OFF_W-1:0]    page_offset_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [BIT_W-1:0]    flip_bit_o,
  output logic [ADDR64_W-1:0] target_phys_o,
  output logic [ADDR64_W-1:0] target_virt_o,
  output logic [ADDR64_W-1:0] origin_phys_o,
  output logic                last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfns_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_frame_i (entry_frame_i),
    .entry_slot_i  (entry_slot_i),
    .base_frame_i  (base_frame_i),
    .page_offset_i (page_offset_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .hit_o         (hit_o),
    .flip_bit_o    (flip_bit_o),
    .target_phys_o (target_phys_o),
    .target_virt_o (target_virt_o),
    .origin_phys_o (origin_phys_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/bfns_chk.sv =====
module bfns_chk import bfns_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          action_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                hit_o,
  input logic [BIT_W-1:0]    flip_bit_o,
  input logic [ADDR64_W-1:0] target_phys_o,
  input logic [ADDR64_W-1:0] target_virt_o,
  input logic [ADDR64_W-1:0] origin_phys_o,
  input logic                last_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(flip_bit_o) && $stable(target_phys_o) && $stable(target_virt_o) &&
      $stable(origin_phys_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // a query blocks further input while it runs
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_QUERY) |=> !in_ready_o)
    else $error("input ready right after query");

  // a miss beat is the sole, last beat with cleared target fields
  a_miss_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> last_o && (flip_bit_o == '0) &&
      (target_phys_o == '0) && (target_virt_o == '0))
    else $error("miss beat malformed");

  // a hit differs from the base exactly in the flipped frame bit
  a_hit_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |->
      ((target_phys_o ^ origin_phys_o) == (64'd1 << ({2'b00, flip_bit_o} + 7'd12))))
    else $error("hit address not one bit from base");

endmodule

bind bit_flip_neighbour_search_core bfns_chk u_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bfns_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_ITEMS  = 400;
  localparam int LONG_ENTRIES = 64;

  // Action code 3 is not in the package; the block ignores it
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // One result beat as the block should emit it
  typedef struct packed {
    logic                hit;
    logic [BIT_W-1:0]    flip_bit;
    logic [ADDR64_W-1:0] target_phys;
    logic [ADDR64_W-1:0] target_virt;
    logic [ADDR64_W-1:0] origin_phys;
    logic                last;
  } nbr_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ADDR64_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          action_i;
  logic [FRAME_W-1:0]  entry_frame_i;
  logic [SLOT_W-1:0]   entry_slot_i;
  logic [FRAME_W-1:0]  base_frame_i;
  logic [OFF_W-1:0]    page_offset_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic [BIT_W-1:0]    flip_bit_o;
  logic [ADDR64_W-1:0] target_phys_o;
  logic [ADDR64_W-1:0] target_virt_o;
  logic [ADDR64_W-1:0] origin_phys_o;
  logic                last_o;

  bit_flip_neighbour_search_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_frame_i (entry_frame_i),
    .entry_slot_i  (entry_slot_i),
    .base_frame_i  (base_frame_i),
    .page_offset_i (page_offset_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .flip_bit_o    (flip_bit_o),
    .target_phys_o (target_phys_o),
    .target_virt_o (target_virt_o),
    .origin_phys_o (origin_phys_o),
    .last_o        (last_o)
  );

  // Shadow copy of the table and the pool base
  logic [FRAME_W-1:0]  tbl_frame [TABLE_DEPTH];
  logic [SLOT_W-1:0]   tbl_slot  [TABLE_DEPTH];
  int                  tbl_count;
  logic [ADDR64_W-1:0] pool_base_m;

  // Neighbour beats still to come out, oldest first
  nbr_beat_t neighbour_q [$];
  nbr_beat_t got_beat;
  nbr_beat_t want_beat;

  logic [FRAME_W-1:0] build_frames [$];

  int  err_count;
  int  cycle_count;
  int  beats_checked;
  int  n_clears, n_appends, n_queries, n_ignored;
  int  rand_items;
  int  ready_hold;
  int  ready_pick;

  // Clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output back-pressure: short stalls, rare long ones, and stall-free stretches
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_ready_i <= 1'b1;
      end else if (ready_pick < 70) begin
        out_ready_i <= 1'b1;
        ready_hold  <= $urandom_range(20, 80);
      end else if (ready_pick < 97) begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(20, 60);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_beat = '{hit_o, flip_bit_o, target_phys_o, target_virt_o, origin_phys_o, last_o};
      if (neighbour_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got hit=%0b bit=%0d phys=0x%0h",
                 $time, hit_o, flip_bit_o, target_phys_o);
      end else begin
        want_beat = neighbour_q.pop_front();
        check_field("hit", 64'(want_beat.hit), 64'(got_beat.hit));
        check_field("flip_bit", 64'(want_beat.flip_bit), 64'(got_beat.flip_bit));
        check_field("target_phys", want_beat.target_phys, got_beat.target_phys);
        check_field("target_virt", want_beat.target_virt, got_beat.target_virt);
        check_field("origin_phys", want_beat.origin_phys, got_beat.origin_phys);
        check_field("last", 64'(want_beat.last), 64'(got_beat.last));
        beats_checked++;
      end
    end
  end

  // First filled entry whose frame is not below key
  function automatic int lower_bound_pos(input logic [FRAME_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_frame[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Expected beats of one query; a hit is held back so the final one gets last
  task automatic search_neighbours(input logic [FRAME_W-1:0] base,
                                   input logic [OFF_W-1:0] off);
    logic [FRAME_W-1:0]  key;
    logic [ADDR64_W-1:0] slot64;
    logic [ADDR64_W-1:0] off64;
    nbr_beat_t           held;
    bit                  have_held;
    int                  pos;
    held      = '0;
    have_held = 1'b0;
    off64     = ADDR64_W'(off);
    for (int b = 0; b < NUM_BITS; b++) begin
      key    = base;
      key[b] = ~key[b];
      pos    = lower_bound_pos(key);
      if (pos < tbl_count && tbl_frame[pos] == key) begin
        if (have_held) neighbour_q.push_back(held);
        slot64           = ADDR64_W'(tbl_slot[pos]);
        held.hit         = 1'b1;
        held.flip_bit    = b[BIT_W-1:0];
        held.target_phys = {key, off};
        held.target_virt = pool_base_m + (slot64 << 12) + off64;
        held.origin_phys = {base, off};
        held.last        = 1'b0;
        have_held        = 1'b1;
      end
    end
    if (!have_held) begin
      held             = '0;
      held.origin_phys = {base, off};
    end
    held.last = 1'b1;
    neighbour_q.push_back(held);
  endtask

  task automatic apply_action(input logic [1:0] act, input logic [FRAME_W-1:0] ef,
                              input logic [SLOT_W-1:0] es, input logic [FRAME_W-1:0] bf,
                              input logic [OFF_W-1:0] po);
    case (act)
      ACT_CLEAR: begin
        tbl_count = 0;
        n_clears++;
      end
      ACT_APPEND: begin
        n_appends++;
        // a full table drops the entry
        if (tbl_count < TABLE_DEPTH) begin
          tbl_frame[tbl_count] = ef;
          tbl_slot[tbl_count]  = es;
          tbl_count++;
        end
      end
      ACT_QUERY: begin
        n_queries++;
        search_neighbours(bf, po);
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [FRAME_W-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FRAME_W-1:0];
  endfunction

  // Send one input beat; called and returns at a falling edge
  task automatic send_beat(input logic [1:0] act, input logic [FRAME_W-1:0] ef,
                           input logic [SLOT_W-1:0] es, input logic [FRAME_W-1:0] bf,
                           input logic [OFF_W-1:0] po);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i      <= act;
    entry_frame_i <= ef;
    entry_slot_i  <= es;
    base_frame_i  <= bf;
    page_offset_i <= po;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_action(act, ef, es, bf, po);
    @(negedge clk_i);
  endtask

  task automatic send_clear();
    send_beat(ACT_CLEAR, rand_frame(), SLOT_W'($urandom), rand_frame(), OFF_W'($urandom));
  endtask

  task automatic send_append(input logic [FRAME_W-1:0] f, input logic [SLOT_W-1:0] s);
    send_beat(ACT_APPEND, f, s, rand_frame(), OFF_W'($urandom));
  endtask

  task automatic send_query(input logic [FRAME_W-1:0] f, input logic [OFF_W-1:0] off);
    send_beat(ACT_QUERY, rand_frame(), SLOT_W'($urandom), f, off);
  endtask

  task automatic send_ignored();
    send_beat(ACT_IGNORED, rand_frame(), SLOT_W'($urandom), rand_frame(), OFF_W'($urandom));
  endtask

  // Hold the input off until every expected beat is out, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (neighbour_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pool_base(input logic [ADDR64_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    pool_base_m = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic sort_build_frames();
    logic [FRAME_W-1:0] t;
    int j;
    for (int i = 1; i < build_frames.size(); i++) begin
      t = build_frames[i];
      j = i - 1;
      while (j >= 0 && build_frames[j] > t) begin
        build_frames[j + 1] = build_frames[j];
        j--;
      end
      build_frames[j + 1] = t;
    end
  endtask

  function automatic logic [FRAME_W-1:0] pick_base();
    logic [FRAME_W-1:0] f;
    case ($urandom_range(0, 5))
      0: f = FRAME_W'($urandom_range(0, 15));
      1: f = FRAME_MAX ^ FRAME_W'($urandom_range(0, 15));
      2: f = {$urandom, 20'd0} ^ FRAME_W'($urandom_range(0, 255));
      default: f = rand_frame();
    endcase
    return f;
  endfunction

  // Queries against the table left empty by reset, plus an ignored beat and a clear
  task automatic test_empty_table();
    send_query('0, '0);
    send_query(FRAME_MAX, '1);
    send_ignored();
    send_clear();
  endtask

  // Neighbours on bits 0, 1 and 31, a duplicate frame, and frames at both ends
  task automatic test_basic_hits();
    send_clear();
    send_append(52'd1, 16'h0000);
    send_append(52'd2, 16'hFFFF);
    send_append(52'd2, 16'h1234);
    send_append(52'h8000_0000, 16'h0007);
    send_append(FRAME_MAX ^ 52'd1, 16'hFFFF);
    send_append(FRAME_MAX, 16'h0001);
    send_query('0, 12'hFFF);
    send_query(FRAME_MAX, 12'h000);
    send_query(52'd3, 12'h07B);
    // virtual address wraps with the largest pool base
    wait_idle();
    set_pool_base('1);
    send_query('0, 12'hFFF);
    send_query(52'd3, 12'h000);
  endtask

  // Same search over entries out of frame order
  task automatic test_unsorted_table();
    wait_idle();
    set_pool_base({$urandom, $urandom});
    send_clear();
    send_append(52'd5, 16'h0055);
    send_append(52'd1, 16'h0011);
    send_append(52'd4, 16'h0044);
    send_query(52'd0, 12'h800);
    send_query(52'd5, 12'h001);
  endtask

  // A longer ascending table so each search takes several probes
  task automatic test_long_table();
    logic [FRAME_W-1:0] f;
    wait_idle();
    set_pool_base({$urandom, 32'd0});
    send_clear();
    f = 52'h4_0000;
    for (int i = 0; i < LONG_ENTRIES; i++) begin
      send_append(f, 16'hFFFF - i[SLOT_W-1:0]);
      f = f + FRAME_W'($urandom_range(1, 3));
    end
    send_query(52'h4_0000, 12'hABC);
    send_query(52'h4_0010, 12'h000);
    send_query(FRAME_MAX, 12'hFFF);
    wait_idle();
  endtask

  // Mostly sorted tables built around a base, with some noise mixed in
  task automatic test_random_sequences();
    logic [FRAME_W-1:0]  base;
    logic [FRAME_W-1:0]  f;
    logic [OFF_W-1:0]    off;
    logic [ADDR64_W-1:0] pb;
    bit                  all_bits;
    int                  extra;
    int                  pick;
    int                  bit_idx;
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: pb = '0;
          1: pb = '1;
          default: pb = {$urandom, $urandom};
        endcase
        set_pool_base(pb);
      end
      base = pick_base();
      build_frames.delete();
      all_bits = ($urandom_range(0, 7) == 0);
      for (int b = 0; b < NUM_BITS; b++) begin
        if (all_bits || $urandom_range(0, 5) == 0) begin
          f    = base;
          f[b] = ~f[b];
          build_frames.push_back(f);
        end
      end
      extra = $urandom_range(0, 8);
      repeat (extra) begin
        pick = $urandom_range(0, 3);
        f = base;
        case (pick)
          0: f = rand_frame();
          1: f[15:0] = f[15:0] ^ 16'($urandom_range(0, 65535));
          2: if (build_frames.size() > 0)
               f = build_frames[$urandom_range(0, build_frames.size() - 1)];
          default: ;
        endcase
        build_frames.push_back(f);
      end
      if ($urandom_range(0, 9) != 0) sort_build_frames();
      if ($urandom_range(0, 9) != 0) begin
        send_clear();
        rand_items++;
      end
      foreach (build_frames[i]) begin
        if ($urandom_range(0, 19) == 0) send_ignored();
        send_append(build_frames[i], SLOT_W'($urandom));
        rand_items++;
      end
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        f = base;
        if (pick >= 8) begin
          f = rand_frame();
        end else if (pick >= 6) begin
          bit_idx    = $urandom_range(0, FRAME_W - 1);
          f[bit_idx] = ~f[bit_idx];
        end
        case ($urandom_range(0, 5))
          0: off = '0;
          1: off = '1;
          default: off = OFF_W'($urandom);
        endcase
        send_query(f, off);
        rand_items++;
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_CLEAR;
    entry_frame_i = '0;
    entry_slot_i  = '0;
    base_frame_i  = '0;
    page_offset_i = '0;
    out_ready_i   = 1'b0;
    ready_hold    = 0;
    tbl_count     = 0;
    pool_base_m   = '0;
    err_count     = 0;
    cycle_count   = 0;
    beats_checked = 0;
    n_clears      = 0;
    n_appends     = 0;
    n_queries     = 0;
    n_ignored     = 0;
    rand_items    = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_basic_hits();
    test_unsorted_table();
    test_long_table();
    test_random_sequences();
    wait_idle();

    $display("Ran %0d clears, %0d appends, %0d queries and %0d ignored beats",
             n_clears, n_appends, n_queries, n_ignored);
    $display("Checked %0d result beats, with duplicate frames, unsorted tables %s",
             beats_checked, "and pool base extremes");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
